/* design/smab_pkg.sv */
// ----------------------------------------------------------------------------
// smab_pkg
// shared constants and types of the six-axis moving average with gyro bias
// ----------------------------------------------------------------------------
package smab_pkg;

  localparam int NumChan       = 6;
  localparam int FieldW        = 16;
  localparam int DataW         = NumChan * FieldW;
  localparam int DefWindow     = 10;
  localparam int DefSampleBits = 16;
  localparam int AddrW         = 4;
  localparam int PDataW        = 32;
  localparam int NumBias       = 3;
  localparam int FirstGyro     = 3;

  typedef enum logic [1:0] {
    REG_GYRO_X_BIAS = 2'd0,
    REG_GYRO_Y_BIAS = 2'd1,
    REG_GYRO_Z_BIAS = 2'd2
  } reg_idx_e;

endpackage

/* design/smab_cell.sv */
// ----------------------------------------------------------------------------
// smab_cell
// one tap of the sample window, holding one sample of every channel
// ----------------------------------------------------------------------------
module smab_cell import smab_pkg::*; #(
  parameter int SampleBits = DefSampleBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  shift_i,
  input  logic [NumChan-1:0][SampleBits-1:0]    sample_i,
  output logic [NumChan-1:0][SampleBits-1:0]    sample_o
);

  logic [NumChan-1:0][SampleBits-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

/* design/smab_avg.sv */
// ----------------------------------------------------------------------------
// smab_avg
// signed window sum divided by the window length, truncated toward zero
// ----------------------------------------------------------------------------
module smab_avg import smab_pkg::*; #(
  parameter int Window     = DefWindow,
  parameter int SampleBits = DefSampleBits
) (
  input  logic                                                 clk_i,
  input  logic                                                 en_i,
  input  logic signed [SampleBits+$clog2(Window)-1:0]          sum_i,
  output logic signed [SampleBits:0]                           avg_o
);

  localparam int Lg   = $clog2(Window);
  localparam int SumW = SampleBits + Lg;
  localparam int MulW = SumW + 1;
  localparam int ProdW = 2 * SumW + 1;
  localparam longint unsigned RecipL =
    ((64'd1 << (SumW + Lg)) + 64'(Window) - 64'd1) / 64'(Window);
  localparam logic [MulW-1:0] Recip = MulW'(RecipL);

  logic [SumW-1:0]       mag_q;
  logic                  neg_q;
  logic [ProdW-1:0]      prod;
  logic [SampleBits-1:0] quot_q;
  logic                  neg2_q;

  assign prod = ProdW'(mag_q) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
      neg_q  <= sum_i[SumW-1];
      quot_q <= prod[SumW+Lg +: SampleBits];
      neg2_q <= neg_q;
    end
  end

  assign avg_o = neg2_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});

endmodule

/* design/six_axis_moving_average_bias.sv */
// ----------------------------------------------------------------------------
// six_axis_moving_average_bias
// moving average over six inertial channels with gyro bias removal
// ----------------------------------------------------------------------------
// One sample of all six axes is taken per clock cycle while the output is not
// stalled, and one averaged sample comes out per input. Its result goes through
// the running sum, divider and output register. The window is a chain of
// Window taps that shifts on every accepted sample. Each channel keeps a
// running sum that adds the new sample and drops the one leaving the last
// tap, so the rate is set by that single add path. The division by Window is
// a reciprocal multiply in a two-stage unit per channel. Window and sums are
// zero after reset, so the first Window-1 results average in those zeros.
// Gyro outputs have the bias registers subtracted and saturate to 16 bits.
// The whole pipeline stalls while a result waits.
// ----------------------------------------------------------------------------
module six_axis_moving_average_bias import smab_pkg::*; #(
  parameter int Window     = DefWindow,
  parameter int SampleBits = DefSampleBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [DataW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z
  output logic [DataW-1:0]  m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  localparam int Lg   = $clog2(Window);
  localparam int SumW = SampleBits + Lg;
  localparam int WideW = FieldW + 2;

  logic adv;
  logic acc;
  logic v1_q, v2_q, v3_q;
  logic out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic [DataW-1:0] out_data_d;
  logic [FieldW-1:0] bias_q [NumBias];
  reg_idx_e reg_idx;
  logic wr_en;

  logic [NumChan-1:0][SampleBits-1:0] tap [Window+1];
  logic signed [SumW-1:0]             sum_q [NumChan];
  logic signed [SampleBits:0]         avg [NumChan];

  assign adv           = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBias; i++) begin
        bias_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_GYRO_X_BIAS: bias_q[0] <= pwdata[FieldW-1:0];
        REG_GYRO_Y_BIAS: bias_q[1] <= pwdata[FieldW-1:0];
        REG_GYRO_Z_BIAS: bias_q[2] <= pwdata[FieldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GYRO_X_BIAS: prdata = PDataW'(bias_q[0]);
      REG_GYRO_Y_BIAS: prdata = PDataW'(bias_q[1]);
      REG_GYRO_Z_BIAS: prdata = PDataW'(bias_q[2]);
      default:         prdata = '0;
    endcase
  end

  // window tap chain
  for (genvar c = 0; c < NumChan; c++) begin : g_in
    assign tap[0][c] = s_axis_tdata[c*FieldW +: SampleBits];
  end

  for (genvar k = 0; k < Window; k++) begin : g_tap
    smab_cell #(
      .SampleBits (SampleBits)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (acc),
      .sample_i (tap[k]),
      .sample_o (tap[k+1])
    );
  end

  // running sums and division
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    logic [SampleBits-1:0] new_s;
    logic [SampleBits-1:0] old_s;
    logic signed [SumW-1:0] sum_d;

    assign new_s = tap[0][c];
    assign old_s = tap[Window][c];
    assign sum_d = sum_q[c] + $signed({{Lg{new_s[SampleBits-1]}}, new_s})
                            - $signed({{Lg{old_s[SampleBits-1]}}, old_s});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[c] <= '0;
      end else if (acc) begin
        sum_q[c] <= sum_d;
      end
    end

    smab_avg #(
      .Window     (Window),
      .SampleBits (SampleBits)
    ) u_avg (
      .clk_i (clk_i),
      .en_i  (adv),
      .sum_i (sum_q[c]),
      .avg_o (avg[c])
    );
  end

  // bias removal and saturation
  for (genvar c = 0; c < NumChan; c++) begin : g_out
    logic signed [WideW-1:0] avg_w;

    assign avg_w = $signed({{(WideW-SampleBits-1){avg[c][SampleBits]}}, avg[c]});

    if (c < FirstGyro) begin : g_accel
      assign out_data_d[c*FieldW +: FieldW] = avg_w[FieldW-1:0];
    end else begin : g_gyro
      logic [FieldW-1:0]       b;
      logic signed [WideW-1:0] diff;
      logic [FieldW-1:0]       sat;

      assign b    = bias_q[c-FirstGyro];
      assign diff = avg_w - $signed({{2{b[FieldW-1]}}, b});

      always_comb begin
        if (diff > $signed(WideW'(32767))) begin
          sat = 16'h7fff;
        end else if (diff < -$signed(WideW'(32768))) begin
          sat = 16'h8000;
        end else begin
          sat = diff[FieldW-1:0];
        end
      end

      assign out_data_d[c*FieldW +: FieldW] = sat;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= s_axis_tvalid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* design/smab_checker.sv */
// ----------------------------------------------------------------------------
// smab_assert
// port-level checks of the six-axis moving average block
// ----------------------------------------------------------------------------
module smab_assert import smab_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata,
  input logic             pready
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stage");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind six_axis_moving_average_bias smab_assert u_smab_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

/* sim/smab_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smab_checker
// watches the sample, result and register ports of the six-axis moving average
// ----------------------------------------------------------------------------
// Keeps its own copy of the per-channel sample windows, running sums and gyro
// bias registers. Every accepted sample pushes the averages it must produce;
// every accepted result is compared field by field with the oldest of them.
// Register reads are compared with the tracked bias values.
// ----------------------------------------------------------------------------
module smab_checker import smab_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [DataW-1:0]  s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [DataW-1:0]  m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  input  logic [PDataW-1:0] prdata,
  input  logic              pready,
  output int                errors_o,
  output int                pending_o,
  output int                results_o
);

  localparam int Taps     = DefWindow;
  localparam int FieldMax = 2 ** (FieldW - 1) - 1;
  localparam int FieldMin = -(2 ** (FieldW - 1));

  logic signed [FieldW-1:0] taps_q [NumChan][Taps];
  int                       sums_q [NumChan];
  int                       slot_q;
  logic signed [FieldW-1:0] bias_q [NumBias];
  logic [DataW-1:0]         expected_avgs [$];
  string                    field_names [NumChan];

  int error_count   = 0;
  int pending_count = 0;
  int result_count  = 0;

  assign errors_o  = error_count;
  assign pending_o = pending_count;
  assign results_o = result_count;

  task automatic clear_model();
    for (int c = 0; c < NumChan; c++) begin
      for (int t = 0; t < Taps; t++) taps_q[c][t] = '0;
      sums_q[c] = 0;
    end
    for (int b = 0; b < NumBias; b++) bias_q[b] = '0;
    slot_q = 0;
    expected_avgs.delete();
    pending_count = 0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int bias_slot(input logic [AddrW-1:0] addr);
    case (addr[AddrW-1:2])
      REG_GYRO_X_BIAS: return 0;
      REG_GYRO_Y_BIAS: return 1;
      REG_GYRO_Z_BIAS: return 2;
      default:         return -1;
    endcase
  endfunction

  // replace the oldest tap of each channel and form the six outputs
  function automatic logic [DataW-1:0] slide_window(input logic [DataW-1:0] sample);
    logic [DataW-1:0] avgs;
    int               s;
    int               a;
    for (int c = 0; c < NumChan; c++) begin
      s = $signed(sample[c*FieldW +: FieldW]);
      sums_q[c] = sums_q[c] + s - int'(taps_q[c][slot_q]);
      taps_q[c][slot_q] = s[FieldW-1:0];
      a = sums_q[c] / Taps;
      if (c >= FirstGyro) begin
        a = a - int'(bias_q[c - FirstGyro]);
        if (a > FieldMax) a = FieldMax;
        else if (a < FieldMin) a = FieldMin;
      end
      avgs[c*FieldW +: FieldW] = a[FieldW-1:0];
    end
    slot_q = (slot_q + 1) % Taps;
    return avgs;
  endfunction

  initial begin
    field_names = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                    "avg_gyro_x", "avg_gyro_y", "avg_gyro_z"};
    clear_model();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DataW-1:0] want;
    string            diffs;
    int               slot;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (psel && penable && pready) begin
        slot = bias_slot(paddr);
        if (slot >= 0) begin
          if (pwrite) begin
            bias_q[slot] = pwdata[FieldW-1:0];
          end else if (prdata[FieldW-1:0] !== bias_q[slot]) begin
            report_mismatch($sformatf("read of bias %0d gave %0d, expected %0d", slot,
                                      $signed(prdata[FieldW-1:0]), bias_q[slot]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_avgs.push_back(slide_window(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (expected_avgs.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want  = expected_avgs.pop_front();
          diffs = "";
          for (int c = 0; c < NumChan; c++) begin
            if (m_axis_tdata[c*FieldW +: FieldW] !== want[c*FieldW +: FieldW]) begin
              diffs = {diffs, $sformatf(" %s got %0d expected %0d;", field_names[c],
                                        $signed(m_axis_tdata[c*FieldW +: FieldW]),
                                        $signed(want[c*FieldW +: FieldW]))};
            end
          end
          if (diffs != "") report_mismatch({"result", diffs});
        end
      end
      pending_count = expected_avgs.size();
    end
  end

endmodule

/* sim/tb_six_axis_moving_average_bias.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_six_axis_moving_average_bias
// stimulus and verdict for the six-axis moving average with gyro bias
// ----------------------------------------------------------------------------
// Writes the three gyro bias registers over the register port while the block
// is idle, then streams inertial samples: a directed start covering start-up
// zeros, full-scale windows and bias saturation both ways, followed by random
// phases mixing uniform, full-scale and near-zero runs under several bias
// settings. Both stream sides idle in short random bursts; once the output
// is held off for a long stretch. Checking happens in smab_checker.
// ----------------------------------------------------------------------------
module tb_six_axis_moving_average_bias;
  import smab_pkg::*;

  localparam int                 HalfPeriod  = 5;
  localparam int                 CycleLimit  = 200000;
  localparam int                 DrainCycles = 12;
  localparam int                 HoldCycles  = 60;
  localparam int                 NumPhases   = 5;
  localparam int                 PhaseItems  = 105;
  localparam logic [AddrW-1:0]   UnusedAddr  = AddrW'(4 * NumBias);
  localparam logic [FieldW-1:0]  PosFull     = 16'h7FFF;
  localparam logic [FieldW-1:0]  NegFull     = 16'h8000;

  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_SMALL} sample_mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  logic [DataW-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z
  logic [DataW-1:0]  m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int   mismatches;
  int   pending;
  int   results;
  int   cycle_count    = 0;
  int   samples_sent   = 0;
  int   reg_writes     = 0;
  int   bias_settings  = 0;
  bit   idle_en        = 1'b1;
  bit   hold_req       = 1'b0;
  int   stall_left     = 0;

  always #HalfPeriod clk_i = ~clk_i;

  six_axis_moving_average_bias dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  smab_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors_o (mismatches),
    .pending_o(pending),
    .results_o(results)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: short random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  function automatic logic [AddrW-1:0] reg_addr(input reg_idx_e r);
    return AddrW'({r, 2'b00});
  endfunction

  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [PDataW-1:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    reg_writes++;
  endtask

  task automatic reg_read(input logic [AddrW-1:0] addr);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // upper data bits are junk on purpose; the register keeps only 16 bits
  task automatic set_biases(input logic [FieldW-1:0] bx, by, bz);
    reg_write(reg_addr(REG_GYRO_X_BIAS), {16'($urandom()), bx});
    reg_write(reg_addr(REG_GYRO_Y_BIAS), {16'($urandom()), by});
    reg_write(reg_addr(REG_GYRO_Z_BIAS), {16'($urandom()), bz});
    reg_write(UnusedAddr, $urandom());
    reg_read(reg_addr(REG_GYRO_X_BIAS));
    reg_read(reg_addr(REG_GYRO_Y_BIAS));
    reg_read(reg_addr(REG_GYRO_Z_BIAS));
    reg_read(UnusedAddr);
    bias_settings++;
  endtask

  task automatic send_sample(input logic [DataW-1:0] d);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    samples_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] make_sample(input sample_mix_e mix,
                                                   input logic [NumChan-1:0] signs);
    logic [DataW-1:0] d;
    for (int c = 0; c < NumChan; c++) begin
      case (mix)
        MIX_EXTREME: d[c*FieldW +: FieldW] = signs[c] ? NegFull : PosFull;
        MIX_SMALL:   d[c*FieldW +: FieldW] = FieldW'($urandom_range(0, 40) - 20);
        default:     d[c*FieldW +: FieldW] = FieldW'($urandom());
      endcase
    end
    return d;
  endfunction

  // runs of one kind so that full-scale windows build up and saturate
  task automatic send_random(input int count);
    int                 left;
    int                 run;
    sample_mix_e        mix;
    logic [NumChan-1:0] signs;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0, 1:    mix = MIX_UNIFORM;
        2:       mix = MIX_EXTREME;
        default: mix = MIX_SMALL;
      endcase
      run   = (mix == MIX_EXTREME) ? 12 : $urandom_range(4, 10);
      signs = NumChan'($urandom());
      for (int i = 0; i < run && left > 0; i++) begin
        send_sample(make_sample(mix, signs));
        left--;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // start-up zeros, then full positive windows against the most negative bias
    set_biases(NegFull, NegFull, NegFull);
    send_sample({NegFull, PosFull, 16'hFFF7, 16'h0009, 16'hFFFF, 16'h0001});
    repeat (10) send_sample({NumChan{PosFull}});
    wait_drained();

    // swing to full negative against the most positive bias; crossing sums
    // give small negative averages that must truncate toward zero
    set_biases(PosFull, PosFull, PosFull);
    repeat (10) send_sample({NumChan{NegFull}});
    send_sample('0);
    send_sample({3{16'hFFFF, 16'h0001}});
    send_sample({NumChan{16'hFFF3}});
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_biases(FieldW'($urandom()), FieldW'($urandom()), FieldW'($urandom()));
        1: set_biases('0, '0, '0);
        2: set_biases(PosFull, NegFull, '0);
        3: set_biases(FieldW'($urandom_range(0, 600) - 300),
                      FieldW'($urandom_range(0, 600) - 300),
                      FieldW'($urandom_range(0, 600) - 300));
        default: set_biases(FieldW'($urandom()), NegFull, FieldW'($urandom()));
      endcase
      idle_en = (ph != 2 && ph != NumPhases - 1);
      if (ph == 1) begin
        send_random(30);
        hold_req = 1'b1;
        send_random(PhaseItems - 30);
      end else begin
        send_random(PhaseItems);
      end
      wait_drained();
    end

    $display("covered %0d samples and %0d results under %0d bias settings (%0d reg writes)",
             samples_sent, results, bias_settings, reg_writes);
    $display("included full-scale saturation, a long output hold-off and drain pauses");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
